// ===== hw/rtl/rpd_pkg.sv =====
package rpd_pkg;

	// default filter lengths, as log2 of the window depth
	localparam int HP_LOG2_LEN_DEF    = 4;
	localparam int NOISE_LOG2_LEN_DEF = 4;
	localparam int DET_LOG2_LEN_DEF   = 3;

	localparam logic [6:0]  REFRACTORY_LEN  = 7'd70;
	localparam logic [15:0] THRESH_GAIN     = 16'd6;
	localparam logic [2:0]  MIN_PULSE_WIDTH = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_CLIP_THR   = 3'd0;
	localparam logic [2:0] REG_DETECT_THR = 3'd1;
	localparam logic [2:0] REG_MIN_INHALE = 3'd2;
	localparam logic [2:0] REG_MAX_INHALE = 3'd3;
	localparam logic [2:0] REG_MIN_EXHALE = 3'd4;

	localparam logic [14:0] CLIP_THR_RST   = 15'd30;
	localparam logic [14:0] DETECT_THR_RST = 15'd160;
	localparam logic [15:0] MIN_INHALE_RST = 16'd35;
	localparam logic [15:0] MAX_INHALE_RST = 16'd400;
	localparam logic [15:0] MIN_EXHALE_RST = 16'd200;

	typedef enum logic [1:0] {
		PH_SEARCH   = 2'd0,
		PH_VALIDATE = 2'd1,
		PH_SKIP     = 2'd2
	} pulse_phase_t;

	typedef enum logic {
		BR_INHALE_SEARCH = 1'b0,
		BR_EXHALE_SEARCH = 1'b1
	} breath_phase_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_INHALE = 2'd1,
		EV_EXHALE = 2'd2
	} breath_event_t;

endpackage

// ===== hw/rtl/respiration_phase_detector.sv =====
// Respiration phase detector: one signed 16-bit sensor sample in, one breath
// event code out (none, inhale pulse, exhale pulse) for every sample.
// Input channel: sample with in_valid / in_stall; a beat is taken when
// in_valid is high and in_stall is low. Output channel: breath_event with
// out_valid / out_stall, same rule.
// Configuration: wr_en, wr_index, wr_data write one threshold register per
// clock; write only while no sample is in flight.
// Throughput: one sample per clock while out_stall is low. The chain is a
// seven-register pipeline (input, three moving-average stages with gain and
// gating between them, pulse and spacing logic, output register).
// Each stage moves on when the one after it is empty or moving, so while the
// receiver stalls the block keeps taking samples until every stage is full.
// The window memories have no reset; a per-filter flag masks them to zero
// until each pointer has wrapped once, so no clearing pass is needed.
// Reset (arst_n low) empties the pipeline and returns every filter, the
// pulse finder, the spacing detector and the registers to their defaults.
module respiration_phase_detector import rpd_pkg::*; #(
	parameter int HP_LOG2_LEN    = HP_LOG2_LEN_DEF,
	parameter int NOISE_LOG2_LEN = NOISE_LOG2_LEN_DEF,
	parameter int DET_LOG2_LEN   = DET_LOG2_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  breath_event,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data
);

	localparam int NSTG = 7;

	logic [NSTG:1] vld_q, mv;
	logic          accept;

	logic [14:0] clip_q, detect_q;
	logic [15:0] min_in_q, max_in_q, min_ex_q;

	logic [15:0] x_s1, x_s2, hpm_s2, hp_s3, nin_s3, hp_s4, nm_s4, gated_s5, level_s6;
	logic [15:0] hp_mean, noise_mean, det_mean;
	logic [15:0] hp_a, hp_n, mag, nin, thr, gated;

	pulse_phase_t  pph_q, pph_nx;
	breath_phase_t bph_q, bph_nx;
	breath_event_t event_q, ev;
	logic [2:0]    width_q, width_nx;
	logic [6:0]    refr_q, refr_nx;
	logic [15:0]   gap_q, gap_mid, gap_nx;
	logic          above, hit;

	// stage k moves when the stage after it is free or moving too
	always_comb begin
		mv[NSTG] = vld_q[NSTG] && !out_stall;
		for (int k = NSTG - 1; k >= 1; k--) begin
			mv[k] = vld_q[k] && (!vld_q[k+1] || mv[k+1]);
		end
	end

	assign in_stall     = vld_q[1] && !mv[1];
	assign accept       = in_valid && !in_stall;
	assign out_valid    = vld_q[NSTG];
	assign breath_event = event_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q[1] <= accept || (vld_q[1] && !mv[1]);
			for (int k = 2; k <= NSTG; k++) begin
				vld_q[k] <= mv[k-1] || (vld_q[k] && !mv[k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q   <= CLIP_THR_RST;
			detect_q <= DETECT_THR_RST;
			min_in_q <= MIN_INHALE_RST;
			max_in_q <= MAX_INHALE_RST;
			min_ex_q <= MIN_EXHALE_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_CLIP_THR:   clip_q   <= wr_data[14:0];
				REG_DETECT_THR: detect_q <= wr_data[14:0];
				REG_MIN_INHALE: min_in_q <= wr_data;
				REG_MAX_INHALE: max_in_q <= wr_data;
				REG_MIN_EXHALE: min_ex_q <= wr_data;
				default: ;
			endcase
		end
	end

	rpd_avg #(.LOG2_LEN(HP_LOG2_LEN)) u_hp_avg (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (mv[1]),
		.din   (x_s1),
		.mean  (hp_mean)
	);

	rpd_avg #(.LOG2_LEN(NOISE_LOG2_LEN)) u_noise_avg (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (mv[3]),
		.din   (nin_s3),
		.mean  (noise_mean)
	);

	rpd_avg #(.LOG2_LEN(DET_LOG2_LEN)) u_det_avg (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (mv[5]),
		.din   (gated_s5),
		.mean  (det_mean)
	);

	// magnitude: both differences side by side; -32768 stays -32768
	assign hp_a  = x_s2 - hpm_s2;
	assign hp_n  = hpm_s2 - x_s2;
	assign mag   = ($signed(hp_a) > 16'sd0) ? hp_a : hp_n;
	assign nin   = ($signed(mag) > $signed({1'b0, clip_q})) ? '0 : mag;
	assign thr   = 16'(nm_s4 * THRESH_GAIN);
	assign gated = ($signed(hp_s4) > $signed(thr)) ? hp_s4 : '0;

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1 <= sample;
		end
		if (mv[1]) begin
			x_s2   <= x_s1;
			hpm_s2 <= hp_mean;
		end
		if (mv[2]) begin
			hp_s3  <= hp_a;
			nin_s3 <= nin;
		end
		if (mv[3]) begin
			hp_s4 <= hp_s3;
			nm_s4 <= noise_mean;
		end
		if (mv[4]) begin
			gated_s5 <= gated;
		end
		if (mv[5]) begin
			level_s6 <= det_mean;
		end
	end

	// pulse finder and spacing detector
	always_comb begin
		above    = $signed(level_s6) > $signed({1'b0, detect_q});
		pph_nx   = pph_q;
		width_nx = width_q;
		refr_nx  = refr_q;
		hit      = 1'b0;
		case (pph_q)
			PH_VALIDATE: begin
				if (above) begin
					width_nx = width_q + 3'd1;
					if (width_nx > MIN_PULSE_WIDTH) begin
						pph_nx  = PH_SKIP;
						hit     = 1'b1;
						refr_nx = REFRACTORY_LEN;
					end
				end else begin
					pph_nx = PH_SEARCH;
				end
			end
			PH_SKIP: begin
				refr_nx = refr_q - 7'd1;
				if (refr_nx == 7'd0) begin
					pph_nx = PH_SEARCH;
				end
			end
			default: begin
				if (above) begin
					width_nx = 3'd0;
					pph_nx   = PH_VALIDATE;
				end
			end
		endcase

		bph_nx  = bph_q;
		gap_mid = gap_q;
		ev      = EV_NONE;
		if (!hit) begin
			if (gap_q > max_in_q) begin
				bph_nx = BR_INHALE_SEARCH;
			end
		end else begin
			if (bph_q == BR_INHALE_SEARCH && gap_q > min_ex_q) begin
				gap_mid = '0;
				bph_nx  = BR_EXHALE_SEARCH;
				ev      = EV_INHALE;
			end
			if (bph_nx == BR_EXHALE_SEARCH && gap_mid > min_in_q) begin
				gap_mid = '0;
				bph_nx  = BR_INHALE_SEARCH;
				ev      = EV_EXHALE;
			end
		end
		// counter saturates instead of wrapping
		gap_nx = (gap_mid != 16'hFFFF) ? gap_mid + 16'd1 : gap_mid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pph_q   <= PH_SEARCH;
			width_q <= '0;
			refr_q  <= '0;
			bph_q   <= BR_INHALE_SEARCH;
			gap_q   <= '0;
		end else if (mv[6]) begin
			pph_q   <= pph_nx;
			width_q <= width_nx;
			refr_q  <= refr_nx;
			bph_q   <= bph_nx;
			gap_q   <= gap_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (mv[6]) begin
			event_q <= ev;
		end
	end

endmodule

// ===== hw/rtl/rpd_ram.sv =====
module rpd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/rpd_avg.sv =====
module rpd_avg import rpd_pkg::*; #(
	parameter int LOG2_LEN = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [15:0] din,
	output logic [15:0] mean
);

	localparam int Len = 1 << LOG2_LEN;

	logic [LOG2_LEN-1:0] pos_q, frac_q, pos_inc, raddr;
	logic [15:0]         mean_q, rdata, old_w, diff, dshift;
	logic [LOG2_LEN:0]   frac_sum;
	logic                filled_q;

	// window entries read as zero until the write pointer has wrapped once
	assign old_w    = filled_q ? rdata : '0;
	assign diff     = din - old_w;
	assign dshift   = 16'($signed(diff) >>> LOG2_LEN);
	assign frac_sum = {1'b0, frac_q} + {1'b0, diff[LOG2_LEN-1:0]};
	assign mean     = mean_q + dshift + {15'd0, frac_sum[LOG2_LEN]};
	assign pos_inc  = pos_q + LOG2_LEN'(1);
	// read ahead so the oldest entry is ready when the next beat arrives
	assign raddr    = step ? pos_inc : pos_q;

	rpd_ram #(
		.WIDTH(16),
		.DEPTH(Len)
	) u_win (
		.clk  (clk),
		.we   (step),
		.waddr(pos_q),
		.wdata(din),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			frac_q   <= '0;
			mean_q   <= '0;
			filled_q <= 1'b0;
		end else if (step) begin
			pos_q  <= pos_inc;
			frac_q <= frac_sum[LOG2_LEN-1:0];
			mean_q <= mean;
			if (pos_q == '1) begin
				filled_q <= 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/rpd_chk.sv =====
module rpd_chk import rpd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  breath_event
);

	// input only backs up once every stage is full behind a stalled output
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output side can drain");

	// refractory skip: a pulse event is never followed by another on the next beat
	a_no_adjacent_events: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && breath_event != EV_NONE)
		|=> !(out_valid && breath_event != EV_NONE))
		else $error("two breath events on adjacent beats");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(breath_event)))
		else $error("stalled output beat changed or dropped");

endmodule

bind respiration_phase_detector rpd_chk u_rpd_chk (.*);
